FILE: rtl/core/pcwam_pkg.sv
// Shared types, reply and item codes and constants for the per-client window average monitor.
// Used by pcwam_div5, per_client_window_average_monitor and the verification files.
`timescale 1ns / 1ps

package pcwam_pkg;

    localparam int DEFAULT_MAX_CLIENTS = 32;
    localparam int WINDOW              = 5;
    localparam int SLOT_W              = 3;
    localparam int SUM_W               = 35;
    localparam int DIV_W               = 36;
    localparam int DIV_DIGITS          = DIV_W / 4;

    localparam logic [1:0] CODE_ACCEPTED = 2'd0;
    localparam logic [1:0] CODE_NEXT     = 2'd1;
    localparam logic [1:0] CODE_STOP     = 2'd2;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_SAMPLE   = 1'b1;

    typedef struct packed {
        logic [31:0]       address;
        logic [15:0]       port;
        logic [SLOT_W-1:0] next_slot;
    } entry_t;

    // Quotient digit of a value below 80 divided by five
    function automatic logic [3:0] div5_digit(input logic [6:0] v);
        logic [14:0] prod;
        begin
            prod = 15'(v) * 15'd205;
            return prod[13:10];
        end
    endfunction

endpackage

FILE: rtl/core/pcwam_div5.sv
// Sequential divide-by-five of a signed window sum, truncated toward zero.
// One radix-16 digit per cycle; uses pcwam_pkg for widths and the digit function.
`timescale 1ns / 1ps

module pcwam_div5 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [pcwam_pkg::SUM_W-1:0] dividend,
    output logic                            done,
    output logic signed [31:0]              quotient
);

    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [3:0]                     cnt_reg, cnt_next;
    logic                           neg_reg, neg_next;
    logic [2:0]                     rem_reg, rem_next;
    logic [pcwam_pkg::DIV_W-1:0]    mag_reg, mag_next;
    logic [pcwam_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [pcwam_pkg::SUM_W-1:0]    abs_val;
    logic [6:0]                     part;
    logic [3:0]                     digit;
    logic [6:0]                     part_rem;
    logic [pcwam_pkg::DIV_W-1:0]    quo_signed;

    always_comb
    begin
        abs_val  = dividend[pcwam_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
        part     = {rem_reg, mag_reg[pcwam_pkg::DIV_W-1 -: 4]};
        digit    = pcwam_pkg::div5_digit(part);
        part_rem = part - {1'b0, digit, 2'b00} - 7'(digit);

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        mag_next  = mag_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            neg_next = dividend[pcwam_pkg::SUM_W-1];
            rem_next = '0;
            mag_next = {1'b0, abs_val};
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = part_rem[2:0];
            mag_next = {mag_reg[pcwam_pkg::DIV_W-5:0], 4'd0};
            quo_next = {quo_reg[pcwam_pkg::DIV_W-5:0], digit};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(pcwam_pkg::DIV_DIGITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        mag_reg <= mag_next;
        quo_reg <= quo_next;
    end

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[31:0];
    assign done       = done_reg;

endmodule

FILE: rtl/core/per_client_window_average_monitor.sv
// Top level of the per-client window average monitor: client table, sample ring memory, control.
// Depends on pcwam_pkg and pcwam_div5.
`timescale 1ns / 1ps

// Usage:
//   An item is a transfer on start while busy is low: kind 0 registers the client at
//   client_address/client_port, kind 1 delivers sample_value from that client.
//   A reply shows on reply_code/reply_value for one cycle with result_valid high;
//   the receiver cannot stall and must take it in that cycle.
//   A sample from an unknown client produces no reply; busy simply drops.
//   average_limit is written over cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
//   Write it only while busy is low and no reply is pending.
// Item handling (one item at a time, busy high while it runs):
//   register request: reply in the cycle after the transfer, busy while the five
//     ring slots are cleared one per cycle through the single sample memory write port;
//     a request with the table full replies stop in the cycle after the transfer and is not busy.
//   sample matching table entry k: the reply follows the table search up to entry k
//     (one entry memory read per cycle), five sample memory reads for the sum, and
//     the divide by five.
//   unknown client: busy while the search runs over every registered entry.
// Reset clears the limit, the client count and the control; memory contents stay
// undefined and are only read after a registration has written them.
module per_client_window_average_monitor #(
    parameter int MAX_CLIENTS = pcwam_pkg::DEFAULT_MAX_CLIENTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [31:0]        client_address,
    input  logic [15:0]        client_port,
    input  logic signed [31:0] sample_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] cfg_data,
    output logic               result_valid,
    output logic [1:0]         reply_code,
    output logic signed [31:0] reply_value
);

    localparam int CNT_W   = $clog2(MAX_CLIENTS + 1);
    localparam int IDX_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int SMP_N   = pcwam_pkg::WINDOW * MAX_CLIENTS;
    localparam int SA_W    = $clog2(SMP_N);
    localparam int SUM_W   = pcwam_pkg::SUM_W;
    localparam int CMP_W   = SUM_W + 3;
    localparam int SLOT_W  = pcwam_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_DIVIDE = 3'd4;

    pcwam_pkg::entry_t entry_mem [MAX_CLIENTS];
    logic [31:0]       sample_mem [SMP_N];

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   search_idx_reg, search_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]  step_reg, step_next;
    logic               pend_reg, pend_next;
    logic [SLOT_W-1:0]  pend_j_reg, pend_j_next;
    logic               result_valid_reg, result_valid_next;
    logic signed [31:0] limit_reg, limit_next;

    logic [31:0]        key_addr_reg, key_addr_next;
    logic [15:0]        key_port_reg, key_port_next;
    logic [31:0]        sample_reg, sample_next;
    logic [SA_W-1:0]    base_reg, base_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [1:0]         reply_code_reg, reply_code_next;
    logic [31:0]        reply_value_reg, reply_value_next;

    logic               ent_we;
    logic [IDX_W-1:0]   ent_waddr;
    pcwam_pkg::entry_t  ent_wdata;
    logic [IDX_W-1:0]   ent_raddr;
    pcwam_pkg::entry_t  ent_rdata_reg;

    logic               smp_we;
    logic [SA_W-1:0]    smp_waddr;
    logic [31:0]        smp_wdata;
    logic [SA_W-1:0]    smp_raddr;
    logic [31:0]        smp_rdata_reg;

    logic               accept;
    logic               match;
    logic [SA_W-1:0]    base_new;
    logic [SA_W-1:0]    base_match;
    logic [SLOT_W-1:0]  slot_cur;
    logic [SLOT_W-1:0]  slot_after;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quotient;
    logic signed [CMP_W-1:0] sum_x4;
    logic signed [CMP_W-1:0] limit_x;
    logic signed [CMP_W-1:0] limit_x15;
    logic               stop_flag;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign base_new   = (SA_W'(count_reg[IDX_W-1:0]) << 2) + SA_W'(count_reg[IDX_W-1:0]);
    assign base_match = (SA_W'(cmp_idx_reg) << 2) + SA_W'(cmp_idx_reg);
    assign match      = cmp_valid_reg && (ent_rdata_reg.address == key_addr_reg)
                        && (ent_rdata_reg.port == key_port_reg);
    assign slot_cur   = (ent_rdata_reg.next_slot >= SLOT_W'(pcwam_pkg::WINDOW)) ? '0
                        : ent_rdata_reg.next_slot;
    assign slot_after = (slot_cur == SLOT_W'(pcwam_pkg::WINDOW - 1)) ? '0
                        : slot_cur + 1'b1;

    assign ent_raddr = search_idx_reg[IDX_W-1:0];
    assign smp_raddr = base_reg + SA_W'(step_reg);

    assign sum_x4    = {{(CMP_W - SUM_W - 2){sum_reg[SUM_W-1]}}, sum_reg, 2'b00};
    assign limit_x   = CMP_W'(limit_reg);
    assign limit_x15 = (limit_x <<< 4) - limit_x;
    assign stop_flag = (sum_x4 > limit_x15);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        search_idx_next   = search_idx_reg;
        cmp_valid_next    = cmp_valid_reg;
        cmp_idx_next      = cmp_idx_reg;
        step_next         = step_reg;
        pend_next         = 1'b0;
        pend_j_next       = pend_j_reg;
        result_valid_next = 1'b0;
        limit_next        = limit_reg;
        key_addr_next     = key_addr_reg;
        key_port_next     = key_port_reg;
        sample_next       = sample_reg;
        base_next         = base_reg;
        sum_next          = sum_reg;
        reply_code_next   = reply_code_reg;
        reply_value_next  = reply_value_reg;
        ent_we            = 1'b0;
        ent_waddr         = count_reg[IDX_W-1:0];
        ent_wdata         = '{address: client_address, port: client_port, next_slot: '0};
        smp_we            = 1'b0;
        smp_waddr         = base_reg + SA_W'(step_reg);
        smp_wdata         = '0;
        div_start         = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !kind)
                begin
                    result_valid_next = 1'b1;
                    if (count_reg < CNT_W'(MAX_CLIENTS))
                    begin
                        ent_we           = 1'b1;
                        count_next       = count_reg + 1'b1;
                        base_next        = base_new;
                        step_next        = '0;
                        reply_code_next  = pcwam_pkg::CODE_ACCEPTED;
                        reply_value_next = limit_reg;
                        state_next       = S_CLEAR;
                    end
                    else
                    begin
                        reply_code_next  = pcwam_pkg::CODE_STOP;
                        reply_value_next = '0;
                    end
                end
                else if (accept)
                begin
                    key_addr_next   = client_address;
                    key_port_next   = client_port;
                    sample_next     = sample_value;
                    search_idx_next = '0;
                    cmp_valid_next  = 1'b0;
                    state_next      = S_SEARCH;
                end
            end

            S_CLEAR:
            begin
                smp_we    = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == SLOT_W'(pcwam_pkg::WINDOW - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                if (match)
                begin
                    ent_we         = 1'b1;
                    ent_waddr      = cmp_idx_reg;
                    ent_wdata      = '{address: ent_rdata_reg.address,
                                       port: ent_rdata_reg.port,
                                       next_slot: slot_after};
                    smp_we         = 1'b1;
                    smp_waddr      = base_match + SA_W'(slot_cur);
                    smp_wdata      = sample_reg;
                    base_next      = base_match;
                    step_next      = '0;
                    sum_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_SUM;
                end
                else if (search_idx_reg < count_reg)
                begin
                    cmp_valid_next  = 1'b1;
                    cmp_idx_next    = search_idx_reg[IDX_W-1:0];
                    search_idx_next = search_idx_reg + 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            S_SUM:
            begin
                if (step_reg < SLOT_W'(pcwam_pkg::WINDOW))
                begin
                    pend_next   = 1'b1;
                    pend_j_next = step_reg;
                    step_next   = step_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + {{(SUM_W - 32){smp_rdata_reg[31]}}, smp_rdata_reg};
                    if (pend_j_reg == SLOT_W'(pcwam_pkg::WINDOW - 1))
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVIDE;
                    end
                end
            end

            S_DIVIDE:
            begin
                if (div_done)
                begin
                    result_valid_next = 1'b1;
                    reply_code_next   = stop_flag ? pcwam_pkg::CODE_STOP
                                                  : pcwam_pkg::CODE_NEXT;
                    reply_value_next  = div_quotient;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            search_idx_reg   <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_idx_reg      <= '0;
            step_reg         <= '0;
            pend_reg         <= 1'b0;
            pend_j_reg       <= '0;
            result_valid_reg <= 1'b0;
            limit_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            search_idx_reg   <= search_idx_next;
            cmp_valid_reg    <= cmp_valid_next;
            cmp_idx_reg      <= cmp_idx_next;
            step_reg         <= step_next;
            pend_reg         <= pend_next;
            pend_j_reg       <= pend_j_next;
            result_valid_reg <= result_valid_next;
            limit_reg        <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_addr_reg    <= key_addr_next;
        key_port_reg    <= key_port_next;
        sample_reg      <= sample_next;
        base_reg        <= base_next;
        sum_reg         <= sum_next;
        reply_code_reg  <= reply_code_next;
        reply_value_reg <= reply_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= entry_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            sample_mem[smp_waddr] <= smp_wdata;
        end
        smp_rdata_reg <= sample_mem[smp_raddr];
    end

    pcwam_div5 u_div5 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign result_valid = result_valid_reg;
    assign reply_code   = reply_code_reg;
    assign reply_value  = reply_value_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CLIENTS))
        else $error("client count beyond table size");

    a_cmp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare of an unregistered entry");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divide result outside divide state");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind) |=> (busy && !result_valid))
        else $error("sample transfer did not start a search");

endmodule

FILE: verif/per_client_window_average_checker.sv
// Checker for the per-client window average monitor: keeps its own client table and
// sample rings, predicts every reply and compares it with what the block returns.
// Depends on pcwam_pkg; instantiated beside the block by tb_per_client_window_average_monitor.
`timescale 1ns / 1ps

module per_client_window_average_checker #(
    parameter int MAX_CLIENTS = pcwam_pkg::DEFAULT_MAX_CLIENTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               kind,
    input  logic [31:0]        client_address,
    input  logic [15:0]        client_port,
    input  logic signed [31:0] sample_value,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic signed [31:0] cfg_data,
    input  logic               result_valid,
    input  logic [1:0]         reply_code,
    input  logic signed [31:0] reply_value,
    output int                 fail_count,
    output int                 replies_waiting,
    output int                 replies_seen
);

    typedef struct packed {
        logic [1:0]         code;
        logic signed [31:0] value;
    } reply_t;

    logic signed [31:0]           limit_q;
    logic [31:0]                  client_addr_q [MAX_CLIENTS];
    logic [15:0]                  client_port_q [MAX_CLIENTS];
    logic [pcwam_pkg::SLOT_W-1:0] client_slot_q [MAX_CLIENTS];
    logic signed [31:0]           client_ring_q [MAX_CLIENTS][pcwam_pkg::WINDOW];
    int                           client_count;
    reply_t                       replies_due [$];

    function automatic bit window_reply(input logic is_register, input logic [31:0] addr,
                                        input logic [15:0] port, input logic signed [31:0] value,
                                        output reply_t r);
        longint sum;
        longint lim;
        int     hit;
        hit = -1;
        sum = 0;
        r   = '0;
        if (is_register)
        begin
            if (client_count < MAX_CLIENTS)
            begin
                client_addr_q[client_count] = addr;
                client_port_q[client_count] = port;
                client_slot_q[client_count] = '0;
                for (int j = 0; j < pcwam_pkg::WINDOW; j++)
                    client_ring_q[client_count][j] = '0;
                client_count++;
                r.code  = pcwam_pkg::CODE_ACCEPTED;
                r.value = limit_q;
            end
            else
            begin
                r.code  = pcwam_pkg::CODE_STOP;
                r.value = '0;
            end
            return 1'b1;
        end
        for (int i = 0; i < client_count; i++)
            if (hit < 0 && client_addr_q[i] == addr && client_port_q[i] == port)
                hit = i;
        if (hit < 0)
            return 1'b0;
        client_ring_q[hit][client_slot_q[hit]] = value;
        client_slot_q[hit] = (client_slot_q[hit] == pcwam_pkg::WINDOW - 1) ? '0
                             : client_slot_q[hit] + 1'b1;
        for (int j = 0; j < pcwam_pkg::WINDOW; j++)
            sum += longint'(client_ring_q[hit][j]);
        lim     = longint'(limit_q);
        r.code  = (4 * sum > 15 * lim) ? pcwam_pkg::CODE_STOP : pcwam_pkg::CODE_NEXT;
        r.value = 32'(sum / pcwam_pkg::WINDOW);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t due;
        reply_t next_due;
        if (!rst_n)
        begin
            limit_q      = '0;
            client_count = 0;
            replies_due.delete();
            fail_count      = 0;
            replies_waiting = 0;
            replies_seen    = 0;
        end
        else
        begin
            if (result_valid)
            begin
                replies_seen++;
                if (replies_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected reply code %0d value %0d",
                                 $realtime, reply_code, reply_value);
                    fail_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (reply_code !== due.code || reply_value !== due.value)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: reply mismatch: code exp %0d got %0d, ",
                                      "value exp %0d got %0d"},
                                     $realtime, due.code, reply_code, due.value, reply_value);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit_q = cfg_data;
            if (start && !busy)
                if (window_reply(kind == pcwam_pkg::KIND_REGISTER, client_address, client_port,
                                 sample_value, next_due))
                    replies_due.push_back(next_due);
            replies_waiting = replies_due.size();
        end
    end

endmodule

FILE: verif/tb_per_client_window_average_monitor.sv
// Testbench top for the per-client window average monitor: clock, reset, register and
// sample stimulus over several limit settings, timeout and verdict.
// Depends on pcwam_pkg, the block itself and per_client_window_average_checker.
`timescale 1ns / 1ps

module tb_per_client_window_average_monitor;

    localparam int MAX_CLIENTS  = pcwam_pkg::DEFAULT_MAX_CLIENTS;
    localparam int DRAIN_CYCLES = MAX_CLIENTS + 24;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 280;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               kind;
    logic [31:0]        client_address;
    logic [15:0]        client_port;
    logic signed [31:0] sample_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic signed [31:0] cfg_data;
    logic               result_valid;
    logic [1:0]         reply_code;
    logic signed [31:0] reply_value;

    int                 fail_count;
    int                 replies_waiting;
    int                 replies_seen;
    int                 cycle_count;
    int                 gap_pct;
    int                 registers_sent;
    int                 samples_known;
    int                 samples_unknown;
    int                 limits_written;
    logic signed [31:0] limit_now;
    logic [31:0]        known_addr [$];
    logic [15:0]        known_port [$];

    per_client_window_average_monitor #(
        .MAX_CLIENTS(MAX_CLIENTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .client_address(client_address),
        .client_port   (client_port),
        .sample_value  (sample_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .reply_code    (reply_code),
        .reply_value   (reply_value)
    );

    per_client_window_average_checker #(
        .MAX_CLIENTS(MAX_CLIENTS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .client_address (client_address),
        .client_port    (client_port),
        .sample_value   (sample_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .reply_code     (reply_code),
        .reply_value    (reply_value),
        .fail_count     (fail_count),
        .replies_waiting(replies_waiting),
        .replies_seen   (replies_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic k, input logic [31:0] addr, input logic [15:0] port,
                             input logic signed [31:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start          <= 1'b1;
        kind           <= k;
        client_address <= addr;
        client_port    <= port;
        sample_value   <= value;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    task automatic register_client(input logic [31:0] addr, input logic [15:0] port);
        send_item(pcwam_pkg::KIND_REGISTER, addr, port, $urandom);
        registers_sent++;
        if (known_addr.size() < MAX_CLIENTS)
        begin
            known_addr.push_back(addr);
            known_port.push_back(port);
        end
    endtask

    task automatic send_sample(input logic [31:0] addr, input logic [15:0] port,
                               input logic signed [31:0] value);
        send_item(pcwam_pkg::KIND_SAMPLE, addr, port, value);
        samples_known++;
    endtask

    task automatic write_limit(input logic signed [31:0] value);
        start <= 1'b0;
        while (replies_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_now = value;
        limits_written++;
    endtask

    function automatic logic signed [31:0] pick_sample();
        longint near_limit;
        near_limit = (longint'(limit_now) * 3) / 4 + longint'($urandom_range(4000)) - 2000;
        case ($urandom_range(3))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return 32'(near_limit);
        endcase
    endfunction

    task automatic run_phase(input int items);
        int          produced;
        int          pick;
        int          idx;
        logic [31:0] addr;
        logic [15:0] port;
        produced = 0;
        while (produced < items)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                if (known_addr.size() > 0 && $urandom_range(3) == 0)
                begin
                    idx  = $urandom_range(known_addr.size() - 1);
                    addr = known_addr[idx];
                    port = known_port[idx];
                end
                else
                begin
                    addr = $urandom;
                    port = $urandom;
                end
                register_client(addr, port);
                produced++;
            end
            else if (pick < 88 && known_addr.size() > 0)
            begin
                idx = $urandom_range(known_addr.size() - 1);
                send_sample(known_addr[idx], known_port[idx], pick_sample());
                produced++;
            end
            else
            begin
                send_item(pcwam_pkg::KIND_SAMPLE, $urandom, $urandom, pick_sample());
                samples_unknown++;
                produced++;
            end
        end
    endtask

    initial
    begin
        cycle_count     = 0;
        registers_sent  = 0;
        samples_known   = 0;
        samples_unknown = 0;
        limits_written  = 0;
        limit_now       = '0;
        gap_pct         = 21;
        rst_n           = 1'b0;
        start           = 1'b0;
        kind            = pcwam_pkg::KIND_REGISTER;
        client_address  = '0;
        client_port     = '0;
        sample_value    = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_limit(32'sh000A_0000);
        register_client(32'hFFFF_FFFF, 16'hFFFF);
        register_client(32'h0000_0000, 16'h0000);
        register_client(32'hFFFF_FFFF, 16'hFFFF);
        repeat (5) send_sample(32'hFFFF_FFFF, 16'hFFFF, 32'sh7FFF_FFFF);
        repeat (5) send_sample(32'hFFFF_FFFF, 16'hFFFF, 32'sh8000_0000);
        send_item(pcwam_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 16'h0000, 32'sd5);
        send_item(pcwam_pkg::KIND_SAMPLE, 32'h0000_0000, 16'hFFFF, 32'sd5);
        samples_unknown += 2;
        send_sample(32'h0, 16'h0, -32'sd1);
        send_sample(32'h0, 16'h0, 32'sd1);
        send_sample(32'h0, 16'h0, -32'sd7);
        send_sample(32'h0, 16'h0, 32'sd2457607);
        send_sample(32'h0, 16'h0, 32'sd1);

        write_limit(32'sh7FFF_FFFF);
        run_phase(PHASE_ITEMS);
        gap_pct = 77;
        write_limit(32'sh8000_0000);
        run_phase(PHASE_ITEMS);
        write_limit($urandom);
        run_phase(PHASE_ITEMS);
        gap_pct = 0;
        write_limit(32'sh0000_0000);
        run_phase(PHASE_ITEMS);
        write_limit(32'sh0003_0000);
        run_phase(PHASE_ITEMS);

        start <= 1'b0;
        while (replies_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d register requests, %0d samples from known and %0d from unknown %s",
                 registers_sent, samples_known, samples_unknown, "clients");
        $display("under %0d limit settings; %0d replies compared, %0d still outstanding",
                 limits_written, replies_seen, replies_waiting);
        if (fail_count == 0 && replies_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: per_client_window_average_monitor.f
rtl/core/pcwam_pkg.sv
rtl/core/pcwam_div5.sv
rtl/core/per_client_window_average_monitor.sv
verif/per_client_window_average_checker.sv
verif/tb_per_client_window_average_monitor.sv
